/* sv/gcet_pkg.sv */
// ----------------------------------------------------------------------------
// gcet_pkg
// Types, register map and Gray code helpers for the Gray-coded event timer.
// ----------------------------------------------------------------------------
package gcet_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 64;

  // request kinds
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // register map, 32-bit words
  localparam logic [2:0] REG_CNT_LO   = 3'd0;
  localparam logic [2:0] REG_CNT_HI   = 3'd1;
  localparam logic [2:0] REG_CAP_LO   = 3'd2;
  localparam logic [2:0] REG_CAP_HI   = 3'd3;
  localparam logic [2:0] REG_MATCH_LO = 3'd4;
  localparam logic [2:0] REG_MATCH_HI = 3'd5;
  localparam logic [2:0] REG_CTRL     = 3'd7;

  // control register bits
  localparam int CTRL_FLAG_BIT = 0;
  localparam int CTRL_IRQ_BIT  = 1;

  // one request as held in the input stage
  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        reg_index;
    logic [WORD_W-1:0] write_data;
  } gcet_item_t;

  // one result as produced by the core
  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq;
  } gcet_result_t;

  function automatic logic [CNT_W-1:0] gray_encode(input logic [CNT_W-1:0] v);
    return v ^ (v >> 1);
  endfunction

  // prefix xor from the top bit down, six doubling steps
  function automatic logic [CNT_W-1:0] gray_decode(input logic [CNT_W-1:0] g);
    logic [CNT_W-1:0] b;
    b = g;
    b = b ^ (b >> 1);
    b = b ^ (b >> 2);
    b = b ^ (b >> 4);
    b = b ^ (b >> 8);
    b = b ^ (b >> 16);
    b = b ^ (b >> 32);
    return b;
  endfunction

endpackage

/* sv/gcet_core.sv */
// ----------------------------------------------------------------------------
// gcet_core
// Timer state, register file and match comparator; one request per update.
// ----------------------------------------------------------------------------
module gcet_core import gcet_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         upd,
  input  gcet_item_t   item,
  output gcet_result_t result
);

  logic [CNT_W-1:0] tick_count, tick_count_next;
  logic [CNT_W-1:0] captured_gray, captured_gray_next;
  logic [CNT_W-1:0] match_gray_value, match_gray_value_next;
  logic             match_armed, match_armed_next;
  logic             event_flag, event_flag_next;
  logic             irq_enable, irq_enable_next;
  logic [CNT_W-1:0] count_gray;
  logic             armed_pre;
  logic             flag_pre;
  logic             fire;
  logic [WORD_W-1:0] rd;

  assign count_gray = gray_encode(tick_count);

  // register access and tick
  always_comb begin
    tick_count_next       = tick_count;
    captured_gray_next    = captured_gray;
    match_gray_value_next = match_gray_value;
    armed_pre             = match_armed;
    flag_pre              = event_flag;
    irq_enable_next       = irq_enable;
    rd                    = '0;
    case (item.command)
      CMD_TICK: begin
        tick_count_next = tick_count + CNT_W'(1);
      end
      CMD_READ: begin
        case (item.reg_index)
          REG_CNT_LO: begin
            captured_gray_next = count_gray;
            rd = count_gray[WORD_W-1:0];
          end
          REG_CNT_HI: begin
            captured_gray_next = count_gray;
            rd = count_gray[CNT_W-1:WORD_W];
          end
          REG_CAP_LO:   rd = captured_gray[WORD_W-1:0];
          REG_CAP_HI:   rd = captured_gray[CNT_W-1:WORD_W];
          REG_MATCH_LO: rd = match_gray_value[WORD_W-1:0];
          REG_MATCH_HI: rd = match_gray_value[CNT_W-1:WORD_W];
          REG_CTRL: begin
            rd[CTRL_FLAG_BIT] = event_flag;
            rd[CTRL_IRQ_BIT]  = irq_enable;
          end
          default: rd = '0;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_index)
          REG_MATCH_LO: match_gray_value_next[WORD_W-1:0] = item.write_data;
          REG_MATCH_HI: begin
            match_gray_value_next[CNT_W-1:WORD_W] = item.write_data;
            armed_pre = 1'b1;
          end
          REG_CTRL: begin
            irq_enable_next = item.write_data[CTRL_IRQ_BIT];
            if (item.write_data[CTRL_FLAG_BIT]) begin
              flag_pre = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // one-shot comparator on the state after this request
  assign fire             = armed_pre && (tick_count_next >= gray_decode(match_gray_value_next));
  assign match_armed_next = armed_pre && !fire;
  assign event_flag_next  = flag_pre || fire;

  assign result.read_data = rd;
  assign result.irq       = event_flag_next && irq_enable_next;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      captured_gray    <= '0;
      match_gray_value <= '0;
      match_armed      <= 1'b0;
      event_flag       <= 1'b0;
      irq_enable       <= 1'b0;
    end else if (upd) begin
      tick_count       <= tick_count_next;
      captured_gray    <= captured_gray_next;
      match_gray_value <= match_gray_value_next;
      match_armed      <= match_armed_next;
      event_flag       <= event_flag_next;
      irq_enable       <= irq_enable_next;
    end
  end

  // a tick moves the count on by exactly one
  a_tick_inc: assert property (@(posedge clk) disable iff (rst)
    upd && item.command == CMD_TICK |=> tick_count == $past(tick_count) + CNT_W'(1))
    else $error("count did not advance on tick");

  // the flag only ever rises from an armed comparator, which then disarms
  a_flag_src: assert property (@(posedge clk) disable iff (rst)
    $rose(event_flag) |-> $past(match_armed) || $past(upd && item.command == CMD_WRITE
      && item.reg_index == REG_MATCH_HI))
    else $error("event flag set without an armed match");

  a_disarm: assert property (@(posedge clk) disable iff (rst)
    upd && fire |=> !match_armed && event_flag)
    else $error("comparator stayed armed after firing");

endmodule

/* sv/gray_coded_event_timer.sv */
// ----------------------------------------------------------------------------
// gray_coded_event_timer
// 64-bit free-running event timer with Gray-coded readout and match interrupt.
// ----------------------------------------------------------------------------
// Every request (tick, register read or register write) gives exactly one
// result carrying the read word and the interrupt level after that request.
// Requests pass through an input stage and a result register, so the block
// takes one request per clock while the result side accepts; each result is
// registered when its request leaves the input stage, and the count update,
// Gray decode of the match word and the 64-bit compare all complete
// combinationally between those registers.
// Back-pressure on the result side stalls the input once both stages are full.
module gray_coded_event_timer import gcet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] write_data
  input  logic [4:0]  s_axis_tuser,   // [1:0] command, [4:2] reg_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] read_data, [32] irq, [39:33] zero
);

  gcet_item_t   stage_item;
  logic         stage_valid;
  logic         advance;
  logic         upd;
  gcet_result_t core_result;
  gcet_result_t out_result;

  // handshake between the stages
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !stage_valid || advance;
  assign upd           = stage_valid && advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_item.command    <= s_axis_tuser[1:0];
      stage_item.reg_index  <= s_axis_tuser[4:2];
      stage_item.write_data <= s_axis_tdata;
    end
  end

  gcet_core u_core (
    .clk    (clk),
    .rst    (rst),
    .upd    (upd),
    .item   (stage_item),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tdata = {7'd0, out_result.irq, out_result.read_data};

  // input only stalls when both stages are full and the result is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> stage_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

  // a held request keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("stalled request lost or changed");

endmodule
